// File: src/lrb_pkg.sv
// ----------------------------------------------------------------------------
// lrb_pkg
// Shared types, codes and reset values of the link reconnect supervisor.
// ----------------------------------------------------------------------------
package lrb_pkg;

	// Default cap on the network count reported by a finished scan
	localparam int unsigned MAX_REPORTED_DEF = 24;

	// Configuration reset values
	localparam logic [15:0] CONNECT_TIMEOUT_RST = 16'd15000;
	localparam logic [15:0] BACKOFF_MIN_RST     = 16'd2000;
	localparam logic [15:0] BACKOFF_MAX_RST     = 16'd30000;
	localparam logic [15:0] SCAN_TIMEOUT_RST    = 16'd20000;

	// Fixed widths of the stream payloads
	localparam int unsigned IN_USER_W  = 3;
	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_USER_W = 4;
	localparam int unsigned OUT_FIX_W  = 39;

	// Driver disconnect reason codes with a class of their own
	localparam logic [7:0] RSN_NOT_FOUND         = 8'd201;
	localparam logic [7:0] RSN_AUTH_EXPIRE       = 8'd2;
	localparam logic [7:0] RSN_HANDSHAKE_TIMEOUT = 8'd15;
	localparam logic [7:0] RSN_AUTH_FAIL         = 8'd202;
	localparam logic [7:0] RSN_ASSOC_FAIL        = 8'd204;
	localparam logic [7:0] RSN_HANDSHAKE_FAIL    = 8'd205;

	typedef enum logic [2:0] {
		OP_TICK      = 3'd0,
		OP_GOT_ADDR  = 3'd1,
		OP_LINK_DROP = 3'd2,
		OP_RECONNECT = 3'd3,
		OP_SCAN_REQ  = 3'd4,
		OP_SCAN_END  = 3'd5
	} op_t;

	typedef enum logic [4:0] {
		PH_IDLE       = 5'b00001,
		PH_CONNECTING = 5'b00010,
		PH_CONNECTED  = 5'b00100,
		PH_FAILED     = 5'b01000,
		PH_SCANNING   = 5'b10000
	} phase_t;

	// Phase numbers as reported on the result stream
	localparam logic [2:0] PN_IDLE       = 3'd0;
	localparam logic [2:0] PN_CONNECTING = 3'd1;
	localparam logic [2:0] PN_CONNECTED  = 3'd2;
	localparam logic [2:0] PN_FAILED     = 3'd3;
	localparam logic [2:0] PN_SCANNING   = 3'd4;

	typedef enum logic [3:0] {
		EV_NONE         = 4'd0,
		EV_CONNECTING   = 4'd1,
		EV_CONNECTED    = 4'd2,
		EV_DISCONNECTED = 4'd3,
		EV_FAILED       = 4'd4,
		EV_BUSY         = 4'd5,
		EV_SCAN_FAILED  = 4'd6,
		EV_SCANNING     = 4'd7,
		EV_SCAN_DONE    = 4'd8,
		EV_ALREADY      = 4'd9
	} ev_t;

	typedef enum logic [2:0] {
		CL_NONE     = 3'd0,
		CL_NOTFOUND = 3'd1,
		CL_AUTH     = 3'd2,
		CL_OTHER    = 3'd3,
		CL_TIMEOUT  = 3'd4
	} cls_t;

	typedef enum logic [2:0] {
		REG_NET_CONFIGURED  = 3'd0,
		REG_CONNECT_TIMEOUT = 3'd1,
		REG_BACKOFF_MIN     = 3'd2,
		REG_BACKOFF_MAX     = 3'd3,
		REG_SCAN_TIMEOUT    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] drop_reason;
		logic       scan_start_ok;
		logic       scan_ok;
		logic [7:0] listable_count;
		logic       link_up;
	} item_t;

	typedef struct packed {
		logic [2:0]  phase_now;
		ev_t         event_code;
		cls_t        fail_class;
		logic [15:0] retry_wait_ms;
		logic [15:0] failure_total;
		logic        scan_accepted;
	} res_t;

	function automatic logic [2:0] phase_num(phase_t p);
		logic [2:0] n;
		case (p)
			PH_IDLE:       n = PN_IDLE;
			PH_CONNECTING: n = PN_CONNECTING;
			PH_CONNECTED:  n = PN_CONNECTED;
			PH_FAILED:     n = PN_FAILED;
			PH_SCANNING:   n = PN_SCANNING;
			default:       n = PN_IDLE;
		endcase
		return n;
	endfunction

	function automatic cls_t classify(logic [7:0] reason);
		cls_t c;
		case (reason)
			RSN_NOT_FOUND:         c = CL_NOTFOUND;
			RSN_AUTH_EXPIRE,
			RSN_HANDSHAKE_TIMEOUT,
			RSN_AUTH_FAIL,
			RSN_ASSOC_FAIL,
			RSN_HANDSHAKE_FAIL:    c = CL_AUTH;
			default:               c = CL_OTHER;
		endcase
		return c;
	endfunction

endpackage

// File: src/link_reconnect_backoff_fsm_core.sv
// ----------------------------------------------------------------------------
// link_reconnect_backoff_fsm_core
// Connection supervisor with exponential reconnect backoff and scan control.
// ----------------------------------------------------------------------------
// Takes one request per clock (a millisecond tick or a driver event) unless
// the result side stalls, and returns exactly one result per request; each
// passes the input register, then the result register. The supervisor state
// updates once per request, so requests may follow each other in every
// clock; a stalled master side holds back the slave side only once both
// registers are full. The user must write config through cfg_* only while no
// request is in flight, not enforced by the block; cfg_ready is always high.
module link_reconnect_backoff_fsm_core #(
	parameter int unsigned MAX_REPORTED = lrb_pkg::MAX_REPORTED_DEF,
	localparam int unsigned RW     = $clog2(MAX_REPORTED + 1),
	localparam int unsigned DATA_W = ((lrb_pkg::OUT_FIX_W + RW + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [2:0]                      cfg_index,
	input  logic [15:0]                     cfg_data,
	// Request stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lrb_pkg::IN_USER_W-1:0]   s_tuser,  // [2:0] opcode
	// [7:0] drop_reason, [8] scan_start_ok, [9] scan_ok,
	// [17:10] listable_count, [18] link_up, [23:19] zero
	input  logic [lrb_pkg::IN_DATA_W-1:0]   s_tdata,
	// Result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lrb_pkg::OUT_USER_W-1:0]  m_tuser,  // [3:0] event_code
	// [2:0] phase_now, [5:3] fail_class, [21:6] retry_wait_ms,
	// [37:22] failure_total, [38 +: RW] reported_count,
	// [38+RW] scan_accepted, rest zero
	output logic [DATA_W-1:0]               m_tdata
);

	lrb_pkg::item_t item_in, item_s1;
	lrb_pkg::res_t  res;
	logic           valid_s1;
	logic           take;
	logic           adv;
	logic [RW-1:0]  reported;

	assign cfg_ready = 1'b1;

	// Unpack the request fields
	assign item_in.opcode         = s_tuser[2:0];
	assign item_in.drop_reason    = s_tdata[7:0];
	assign item_in.scan_start_ok  = s_tdata[8];
	assign item_in.scan_ok        = s_tdata[9];
	assign item_in.listable_count = s_tdata[17:10];
	assign item_in.link_up        = s_tdata[18];

	// Consume the held request when the result register has room
	assign adv = valid_s1 && take;

	lrb_ingress u_ingress (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.item_in  (item_in),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	lrb_engine #(
		.MAX_REPORTED (MAX_REPORTED)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (adv),
		.item      (item_s1),
		.res       (res),
		.reported  (reported)
	);

	lrb_egress #(
		.USER_W (lrb_pkg::OUT_USER_W),
		.DATA_W (DATA_W)
	) u_egress (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.user_d   (res.event_code),
		.data_d   (DATA_W'({res.scan_accepted, reported, res.failure_total,
			res.retry_wait_ms, res.fail_class, res.phase_now})),
		.take     (take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

endmodule

// File: src/lrb_ingress.sv
// ----------------------------------------------------------------------------
// lrb_ingress
// Input register: holds one request until the supervisor consumes it.
// ----------------------------------------------------------------------------
module lrb_ingress (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  lrb_pkg::item_t item_in,
	input  logic           adv,
	output logic           valid_s1,
	output lrb_pkg::item_t item_s1
);

	// Take a new request when the stage is empty or drains this cycle
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Payload needs no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
	end

endmodule

// File: src/lrb_engine.sv
// ----------------------------------------------------------------------------
// lrb_engine
// Supervisor state, configuration registers and the combinational next-state
// and result logic for one request.
// ----------------------------------------------------------------------------
module lrb_engine #(
	parameter int unsigned MAX_REPORTED = lrb_pkg::MAX_REPORTED_DEF,
	localparam int unsigned RW = $clog2(MAX_REPORTED + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr,
	input  logic [2:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	input  logic           fire,
	input  lrb_pkg::item_t item,
	output lrb_pkg::res_t  res,
	output logic [RW-1:0]  reported
);

	localparam logic [7:0]    MAX_CMP = 8'(MAX_REPORTED);
	localparam logic [RW-1:0] MAX_RPT = RW'(MAX_REPORTED);

	logic        net_cfg_q;
	logic [15:0] conn_to_q;
	logic [15:0] bo_min_q;
	logic [15:0] bo_max_q;
	logic [15:0] scan_to_q;

	lrb_pkg::phase_t phase_q, phase_d;
	logic [15:0]     elapsed_q, elapsed_d;
	logic [15:0]     wait_q, wait_d;
	logic [15:0]     backoff_q, backoff_d;
	logic [15:0]     fails_q, fails_d;
	lrb_pkg::cls_t   err_q, err_d;

	logic [16:0]     dbl;
	logic [15:0]     backoff_fail;
	logic [15:0]     wait_dec;
	logic            do_fail;
	lrb_pkg::cls_t   fail_cls;
	lrb_pkg::ev_t    ev;
	logic            acc;
	logic [RW-1:0]   rpt;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_cfg_q <= 1'b0;
			conn_to_q <= lrb_pkg::CONNECT_TIMEOUT_RST;
			bo_min_q  <= lrb_pkg::BACKOFF_MIN_RST;
			bo_max_q  <= lrb_pkg::BACKOFF_MAX_RST;
			scan_to_q <= lrb_pkg::SCAN_TIMEOUT_RST;
		end else if (cfg_wr) begin
			case (lrb_pkg::reg_idx_t'(cfg_index))
				lrb_pkg::REG_NET_CONFIGURED:  net_cfg_q <= cfg_data[0];
				lrb_pkg::REG_CONNECT_TIMEOUT: conn_to_q <= cfg_data;
				lrb_pkg::REG_BACKOFF_MIN:     bo_min_q  <= cfg_data;
				lrb_pkg::REG_BACKOFF_MAX:     bo_max_q  <= cfg_data;
				lrb_pkg::REG_SCAN_TIMEOUT:    scan_to_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Backoff after a failure: minimum first, then doubled up to the cap
	assign dbl          = {backoff_q, 1'b0};
	assign backoff_fail = (backoff_q != 16'd0)
		? ((dbl < {1'b0, bo_max_q}) ? dbl[15:0] : bo_max_q)
		: bo_min_q;
	assign wait_dec     = (wait_q != 16'd0) ? wait_q - 16'd1 : wait_q;

	// Next state and event for the request in the input register
	always_comb begin
		phase_d   = phase_q;
		elapsed_d = elapsed_q;
		wait_d    = wait_q;
		backoff_d = backoff_q;
		fails_d   = fails_q;
		err_d     = err_q;
		ev        = lrb_pkg::EV_NONE;
		acc       = 1'b0;
		rpt       = '0;
		do_fail   = 1'b0;
		fail_cls  = lrb_pkg::CL_TIMEOUT;
		case (lrb_pkg::op_t'(item.opcode))
			lrb_pkg::OP_TICK: begin
				wait_d = wait_dec;
				if (phase_q == lrb_pkg::PH_SCANNING) begin
					if (elapsed_q >= scan_to_q) begin
						phase_d = lrb_pkg::PH_IDLE;
						ev      = lrb_pkg::EV_SCAN_FAILED;
					end else begin
						elapsed_d = elapsed_q + 16'd1;
					end
				end else if (net_cfg_q) begin
					if (phase_q == lrb_pkg::PH_IDLE || phase_q == lrb_pkg::PH_FAILED) begin
						if (wait_dec == 16'd0) begin
							phase_d   = lrb_pkg::PH_CONNECTING;
							elapsed_d = 16'd0;
							ev        = lrb_pkg::EV_CONNECTING;
						end
					end else if (phase_q == lrb_pkg::PH_CONNECTING) begin
						if (elapsed_q >= conn_to_q) begin
							do_fail = 1'b1;
						end else begin
							elapsed_d = elapsed_q + 16'd1;
						end
					end
				end
			end
			lrb_pkg::OP_GOT_ADDR: begin
				phase_d   = lrb_pkg::PH_CONNECTED;
				fails_d   = 16'd0;
				backoff_d = 16'd0;
				err_d     = lrb_pkg::CL_NONE;
				ev        = lrb_pkg::EV_CONNECTED;
			end
			lrb_pkg::OP_LINK_DROP: begin
				if (phase_q == lrb_pkg::PH_CONNECTED) begin
					phase_d = lrb_pkg::PH_IDLE;
					wait_d  = 16'd0;
					ev      = lrb_pkg::EV_DISCONNECTED;
				end else if (phase_q == lrb_pkg::PH_CONNECTING) begin
					do_fail  = 1'b1;
					fail_cls = lrb_pkg::classify(item.drop_reason);
				end
			end
			lrb_pkg::OP_RECONNECT: begin
				fails_d   = 16'd0;
				backoff_d = 16'd0;
				err_d     = lrb_pkg::CL_NONE;
				wait_d    = 16'd0;
				if (net_cfg_q) begin
					phase_d   = lrb_pkg::PH_CONNECTING;
					elapsed_d = 16'd0;
					ev        = lrb_pkg::EV_CONNECTING;
				end
			end
			lrb_pkg::OP_SCAN_REQ: begin
				if (phase_q == lrb_pkg::PH_SCANNING) begin
					acc = 1'b1;
					ev  = lrb_pkg::EV_ALREADY;
				end else if (phase_q == lrb_pkg::PH_CONNECTING) begin
					ev = lrb_pkg::EV_BUSY;
				end else if (!item.scan_start_ok) begin
					ev = lrb_pkg::EV_SCAN_FAILED;
				end else begin
					phase_d   = lrb_pkg::PH_SCANNING;
					elapsed_d = 16'd0;
					acc       = 1'b1;
					ev        = lrb_pkg::EV_SCANNING;
				end
			end
			lrb_pkg::OP_SCAN_END: begin
				if (phase_q == lrb_pkg::PH_SCANNING) begin
					if (!item.scan_ok) begin
						phase_d = lrb_pkg::PH_IDLE;
						ev      = lrb_pkg::EV_SCAN_FAILED;
					end else begin
						rpt     = (item.listable_count < MAX_CMP)
							? RW'(item.listable_count) : MAX_RPT;
						phase_d = item.link_up ? lrb_pkg::PH_CONNECTED : lrb_pkg::PH_IDLE;
						wait_d  = 16'd0;
						ev      = lrb_pkg::EV_SCAN_DONE;
					end
				end
			end
			default: ;
		endcase
		// Record a failed attempt and arm the backoff wait
		if (do_fail) begin
			fails_d   = (&fails_q) ? fails_q : fails_q + 16'd1;
			err_d     = fail_cls;
			backoff_d = backoff_fail;
			wait_d    = backoff_fail;
			phase_d   = lrb_pkg::PH_FAILED;
			ev        = lrb_pkg::EV_FAILED;
		end
	end

	// Advance the state once per consumed request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= lrb_pkg::PH_IDLE;
			elapsed_q <= 16'd0;
			wait_q    <= 16'd0;
			backoff_q <= 16'd0;
			fails_q   <= 16'd0;
			err_q     <= lrb_pkg::CL_NONE;
		end else if (fire) begin
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			wait_q    <= wait_d;
			backoff_q <= backoff_d;
			fails_q   <= fails_d;
			err_q     <= err_d;
		end
	end

	assign res.phase_now     = lrb_pkg::phase_num(phase_d);
	assign res.event_code    = ev;
	assign res.fail_class    = err_d;
	assign res.retry_wait_ms = backoff_d;
	assign res.failure_total = fails_d;
	assign res.scan_accepted = acc;
	assign reported          = rpt;

endmodule

// File: src/lrb_egress.sv
// ----------------------------------------------------------------------------
// lrb_egress
// Result register on the master side of the stream.
// ----------------------------------------------------------------------------
module lrb_egress #(
	parameter int unsigned USER_W = lrb_pkg::OUT_USER_W,
	parameter int unsigned DATA_W = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [USER_W-1:0] user_d,
	input  logic [DATA_W-1:0] data_d,
	output logic              take,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [USER_W-1:0] m_tuser,
	output logic [DATA_W-1:0] m_tdata
);

	// Room for a new result when empty or the held one leaves now
	assign take = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (take) begin
			m_tvalid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tuser <= user_d;
			m_tdata <= data_d;
		end
	end

endmodule

// File: src/lrb_checker.sv
// ----------------------------------------------------------------------------
// lrb_checker
// Port-level checks of the supervisor's result stream.
// ----------------------------------------------------------------------------
module lrb_checker #(
	parameter int unsigned MAX_REPORTED = lrb_pkg::MAX_REPORTED_DEF,
	localparam int unsigned RW     = $clog2(MAX_REPORTED + 1),
	localparam int unsigned DATA_W = ((lrb_pkg::OUT_FIX_W + RW + 7) / 8) * 8,
	localparam int unsigned ACC_B  = lrb_pkg::OUT_FIX_W - 1 + RW
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [lrb_pkg::OUT_USER_W-1:0] m_tuser,
	input logic [DATA_W-1:0]              m_tdata
);

	// Hold a stalled result
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Scan accepted only with the scanning or already-scanning events
	a_scan_acc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[ACC_B] ==
			(m_tuser == lrb_pkg::EV_SCANNING || m_tuser == lrb_pkg::EV_ALREADY)))
		else $error("scan_accepted disagrees with event");

	// Network count only with a finished scan
	a_rpt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != lrb_pkg::EV_SCAN_DONE |-> m_tdata[38 +: RW] == '0)
		else $error("reported count outside scan done");

	// A failure leaves the failed phase, a counted failure and a set class
	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == lrb_pkg::EV_FAILED |->
			m_tdata[2:0] == lrb_pkg::PN_FAILED && m_tdata[37:22] != 16'd0 &&
			m_tdata[5:3] != lrb_pkg::CL_NONE)
		else $error("failure event with inconsistent state");

	// Connected event clears the failure record
	a_conn: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == lrb_pkg::EV_CONNECTED |->
			m_tdata[2:0] == lrb_pkg::PN_CONNECTED && m_tdata[37:6] == 32'd0)
		else $error("connected event with stale failure record");

endmodule

bind link_reconnect_backoff_fsm_core lrb_checker #(
	.MAX_REPORTED (MAX_REPORTED)
) u_lrb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tuser  (m_tuser),
	.m_tdata  (m_tdata)
);

// File: bench/link_reconnect_backoff_fsm_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// link_reconnect_backoff_fsm_core_test
// Self-checking bench for the link reconnect supervisor: every accepted
// request runs through a local model of the supervisor, and each result on
// the master side is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module link_reconnect_backoff_fsm_core_test;
	import lrb_pkg::*;

	localparam int unsigned RPT_W          = $clog2(MAX_REPORTED_DEF + 1);
	localparam int unsigned DATA_W         = ((OUT_FIX_W + RPT_W + 7) / 8) * 8;
	localparam int          RESULT_LATENCY = 2;
	localparam int          LIMIT_CYCLES   = 200_000;
	localparam int          IDLE_PCT       = 18;

	// Opcodes the block must ignore
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	typedef struct {
		logic [2:0]       phase;
		ev_t              ev;
		cls_t             cls;
		logic [15:0]      retry_wait;
		logic [15:0]      fails;
		logic [RPT_W-1:0] reported;
		logic             accepted;
	} link_status_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [2:0]            cfg_index;
	logic [15:0]           cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_USER_W-1:0]  s_tuser;   // [2:0] opcode
	// [7:0] drop_reason, [8] scan_start_ok, [9] scan_ok,
	// [17:10] listable_count, [18] link_up, [23:19] zero
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_USER_W-1:0] m_tuser;   // [3:0] event_code
	// [2:0] phase_now, [5:3] fail_class, [21:6] retry_wait_ms,
	// [37:22] failure_total, [38 +: RPT_W] reported_count,
	// [38+RPT_W] scan_accepted, rest zero
	logic [DATA_W-1:0]     m_tdata;

	// Supervisor settings and state as the bench expects them
	logic        cfg_net_on;
	logic [15:0] cfg_conn_to;
	logic [15:0] cfg_bo_min;
	logic [15:0] cfg_bo_max;
	logic [15:0] cfg_scan_to;
	logic [2:0]  sv_phase;
	logic [15:0] sv_elapsed;
	logic [15:0] sv_wait;
	logic [15:0] sv_backoff;
	logic [15:0] sv_fails;
	cls_t        sv_last_err;

	link_status_t expected_status[$];
	int           fail_count;
	int           cycle_count;
	bit           steady;
	int           hold_ask;
	int           hold_left;

	link_reconnect_backoff_fsm_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Supervisor model
	// ------------------------------------------------------------------

	function automatic cls_t reason_class(logic [7:0] r);
		if (r == RSN_NOT_FOUND)
			return CL_NOTFOUND;
		if (r inside {RSN_AUTH_EXPIRE, RSN_HANDSHAKE_TIMEOUT, RSN_AUTH_FAIL,
				RSN_ASSOC_FAIL, RSN_HANDSHAKE_FAIL})
			return CL_AUTH;
		return CL_OTHER;
	endfunction

	function automatic void begin_attempt();
		sv_phase   = PN_CONNECTING;
		sv_elapsed = '0;
	endfunction

	// Count the failure and grow the backoff: minimum first, then doubled up to the cap
	function automatic void record_failure(cls_t c);
		logic [16:0] doubled;
		if (sv_fails != 16'hFFFF)
			sv_fails = sv_fails + 16'd1;
		sv_last_err = c;
		if (sv_backoff != '0) begin
			doubled    = {sv_backoff, 1'b0};
			sv_backoff = (doubled < {1'b0, cfg_bo_max}) ? doubled[15:0] : cfg_bo_max;
		end else begin
			sv_backoff = cfg_bo_min;
		end
		sv_phase = PN_FAILED;
		sv_wait  = sv_backoff;
	endfunction

	// Advance the model by one request and return the status it should report
	function automatic link_status_t predict_status(item_t it);
		link_status_t s;
		s.ev       = EV_NONE;
		s.reported = '0;
		s.accepted = 1'b0;
		case (it.opcode)
			OP_TICK: begin
				if (sv_wait != '0)
					sv_wait = sv_wait - 16'd1;
				if (sv_phase == PN_SCANNING) begin
					if ({1'b0, sv_elapsed} + 17'd1 > {1'b0, cfg_scan_to}) begin
						sv_phase = PN_IDLE;
						s.ev     = EV_SCAN_FAILED;
					end else begin
						sv_elapsed = sv_elapsed + 16'd1;
					end
				end else if (cfg_net_on) begin
					if (sv_phase == PN_IDLE || sv_phase == PN_FAILED) begin
						if (sv_wait == '0) begin
							begin_attempt();
							s.ev = EV_CONNECTING;
						end
					end else if (sv_phase == PN_CONNECTING) begin
						if ({1'b0, sv_elapsed} + 17'd1 > {1'b0, cfg_conn_to}) begin
							record_failure(CL_TIMEOUT);
							s.ev = EV_FAILED;
						end else begin
							sv_elapsed = sv_elapsed + 16'd1;
						end
					end
				end
			end
			OP_GOT_ADDR: begin
				sv_phase    = PN_CONNECTED;
				sv_fails    = '0;
				sv_backoff  = '0;
				sv_last_err = CL_NONE;
				s.ev        = EV_CONNECTED;
			end
			OP_LINK_DROP: begin
				if (sv_phase == PN_CONNECTED) begin
					sv_phase = PN_IDLE;
					sv_wait  = '0;
					s.ev     = EV_DISCONNECTED;
				end else if (sv_phase == PN_CONNECTING) begin
					record_failure(reason_class(it.drop_reason));
					s.ev = EV_FAILED;
				end
			end
			OP_RECONNECT: begin
				sv_fails    = '0;
				sv_backoff  = '0;
				sv_last_err = CL_NONE;
				sv_wait     = '0;
				if (cfg_net_on) begin
					begin_attempt();
					s.ev = EV_CONNECTING;
				end
			end
			OP_SCAN_REQ: begin
				if (sv_phase == PN_SCANNING) begin
					s.accepted = 1'b1;
					s.ev       = EV_ALREADY;
				end else if (sv_phase == PN_CONNECTING) begin
					s.ev = EV_BUSY;
				end else if (!it.scan_start_ok) begin
					s.ev = EV_SCAN_FAILED;
				end else begin
					sv_phase   = PN_SCANNING;
					sv_elapsed = '0;
					s.accepted = 1'b1;
					s.ev       = EV_SCANNING;
				end
			end
			OP_SCAN_END: begin
				if (sv_phase == PN_SCANNING) begin
					if (!it.scan_ok) begin
						sv_phase = PN_IDLE;
						s.ev     = EV_SCAN_FAILED;
					end else begin
						s.reported = (it.listable_count < MAX_REPORTED_DEF) ?
							it.listable_count[RPT_W-1:0] : RPT_W'(MAX_REPORTED_DEF);
						sv_phase = it.link_up ? PN_CONNECTED : PN_IDLE;
						sv_wait  = '0;
						s.ev     = EV_SCAN_DONE;
					end
				end
			end
			default: ;
		endcase
		s.phase      = sv_phase;
		s.cls        = sv_last_err;
		s.retry_wait = sv_backoff;
		s.fails      = sv_fails;
		return s;
	endfunction

	// ------------------------------------------------------------------
	// Stream drivers
	// ------------------------------------------------------------------

	// Offer one request, idling at random first, and log its prediction on accept
	task automatic send_item(input logic [2:0] op, input logic [7:0] reason = '0,
			input logic start_ok = 1'b0, input logic scan_ok = 1'b0,
			input logic [7:0] listable = '0, input logic link_up = 1'b0);
		item_t it;
		it.opcode         = op;
		it.drop_reason    = reason;
		it.scan_start_ok  = start_ok;
		it.scan_ok        = scan_ok;
		it.listable_count = listable;
		it.link_up        = link_up;
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {5'b0, link_up, listable, scan_ok, start_ok, reason};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_status.push_back(predict_status(it));
	endtask

	// Pick a request with random content, biased toward the busy paths
	task automatic send_random_item();
		int          roll;
		logic [2:0]  op;
		logic [7:0]  reason;
		logic [7:0]  special [6];
		special = '{RSN_NOT_FOUND, RSN_AUTH_EXPIRE, RSN_HANDSHAKE_TIMEOUT,
			RSN_AUTH_FAIL, RSN_ASSOC_FAIL, RSN_HANDSHAKE_FAIL};
		roll = $urandom_range(0, 99);
		if (roll < 45)
			op = OP_TICK;
		else if (roll < 60)
			op = OP_LINK_DROP;
		else if (roll < 67)
			op = OP_GOT_ADDR;
		else if (roll < 73)
			op = OP_RECONNECT;
		else if (roll < 85)
			op = OP_SCAN_REQ;
		else if (roll < 97)
			op = OP_SCAN_END;
		else
			op = roll[0] ? OP_SPARE_6 : OP_SPARE_7;
		reason = $urandom_range(0, 1) ? special[$urandom_range(0, 5)] : 8'($urandom_range(0, 255));
		send_item(op, reason, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
			8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	// Hold the request side until every prediction is matched, then let the pipe empty
	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (RESULT_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_NET_CONFIGURED:  cfg_net_on  = value[0];
			REG_CONNECT_TIMEOUT: cfg_conn_to = value;
			REG_BACKOFF_MIN:     cfg_bo_min  = value;
			REG_BACKOFF_MAX:     cfg_bo_max  = value;
			REG_SCAN_TIMEOUT:    cfg_scan_to = value;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Reprogram all registers once the block is idle
	task automatic load_settings(input logic [15:0] net, input logic [15:0] conn_to,
			input logic [15:0] bo_min, input logic [15:0] bo_max, input logic [15:0] scan_to);
		wait_all_results();
		write_reg(REG_NET_CONFIGURED, net);
		write_reg(REG_CONNECT_TIMEOUT, conn_to);
		write_reg(REG_BACKOFF_MIN, bo_min);
		write_reg(REG_BACKOFF_MAX, bo_max);
		write_reg(REG_SCAN_TIMEOUT, scan_to);
	endtask

	// ------------------------------------------------------------------
	// Result side: random stalls, long hold-offs on request
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_ask != 0) begin
			hold_left = hold_ask;
			hold_ask  = 0;
		end
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Match each result against the oldest prediction
	always @(posedge clk) begin : result_check
		link_status_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_status.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				want = expected_status.pop_front();
				check_field("phase_now", 16'(want.phase), 16'(m_tdata[2:0]));
				check_field("event_code", 16'(want.ev), 16'(m_tuser[3:0]));
				check_field("fail_class", 16'(want.cls), 16'(m_tdata[5:3]));
				check_field("retry_wait_ms", want.retry_wait, m_tdata[21:6]);
				check_field("failure_total", want.fails, m_tdata[37:22]);
				check_field("reported_count", 16'(want.reported), 16'(m_tdata[38 +: RPT_W]));
				check_field("scan_accepted", 16'(want.accepted), 16'(m_tdata[38 + RPT_W]));
			end
		end
	end

	// Drop the run if it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Walk every phase and event with short timers
	task automatic test_phase_walk();
		load_settings(16'd1, 16'd2, 16'd3, 16'd5, 16'd2);
		send_item(OP_TICK);                              // attempt at once
		repeat (3) send_item(OP_TICK);                   // stalls into a timeout
		send_item(OP_TICK);                              // wait counts down, no attempt
		send_item(OP_SCAN_REQ, 8'd0, 1'b0);              // driver refuses the scan
		send_item(OP_SCAN_REQ, 8'd0, 1'b1);
		send_item(OP_SCAN_REQ, 8'd0, 1'b1);              // already scanning
		send_item(OP_LINK_DROP, 8'd0);                   // ignored while scanning
		send_item(OP_SCAN_END, 8'd0, 1'b0, 1'b1, 8'd255, 1'b1);
		send_item(OP_LINK_DROP, 8'd0);                   // disconnect
		send_item(OP_LINK_DROP, 8'd255);                 // ignored in idle
		send_item(OP_SCAN_END, 8'd0, 1'b0, 1'b1, 8'd5, 1'b1);  // stray scan end
		send_item(OP_TICK);
		send_item(OP_SCAN_REQ, 8'd0, 1'b1);              // busy while connecting
		send_item(OP_GOT_ADDR);
		send_item(OP_SCAN_REQ, 8'd0, 1'b1);
		send_item(OP_SCAN_END, 8'd0, 1'b1, 1'b0, 8'd9, 1'b1);  // scan error at the end
		send_item(OP_SCAN_REQ, 8'd0, 1'b1);
		send_item(OP_SCAN_END, 8'd0, 1'b1, 1'b1, 8'd23, 1'b0);
		send_item(OP_SCAN_REQ, 8'd0, 1'b1);
		send_item(OP_GOT_ADDR);                          // abandons the scan
		send_item(OP_SPARE_6, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1);
		send_item(OP_SPARE_7, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1);
	endtask

	// Classify each special drop reason and two ordinary ones
	task automatic test_drop_classes();
		logic [7:0] reasons [8];
		reasons = '{RSN_NOT_FOUND, RSN_AUTH_FAIL, RSN_AUTH_EXPIRE, RSN_HANDSHAKE_TIMEOUT,
			RSN_ASSOC_FAIL, RSN_HANDSHAKE_FAIL, 8'd0, 8'd255};
		foreach (reasons[i]) begin
			send_item(OP_RECONNECT);
			send_item(OP_LINK_DROP, reasons[i]);
		end
	endtask

	// Zero timeouts, backoff past the 16-bit cap, minimum above maximum
	task automatic test_timer_extremes();
		load_settings(16'd1, 16'd0, 16'd40000, 16'hFFFF, 16'd0);
		send_item(OP_RECONNECT);
		send_item(OP_TICK);                              // fails on the first tick
		send_item(OP_SCAN_REQ, 8'd0, 1'b1);
		send_item(OP_TICK);                              // scan abandoned on the first tick
		send_item(OP_SCAN_REQ, 8'd0, 1'b1);
		send_item(OP_SCAN_END, 8'd0, 1'b1, 1'b1, 8'd24, 1'b0);  // clears the wait
		send_item(OP_TICK);
		send_item(OP_LINK_DROP, 8'd7);                   // doubling hits the cap
		send_item(OP_LINK_DROP, 8'd7);                   // ignored once failed
		load_settings(16'd1, 16'hFFFF, 16'd9, 16'd4, 16'hFFFF);
		send_item(OP_RECONNECT);
		send_item(OP_LINK_DROP, RSN_AUTH_FAIL);
		send_item(OP_SCAN_REQ, 8'd0, 1'b1);
		send_item(OP_SCAN_END, 8'd0, 1'b1, 1'b1, 8'd0, 1'b0);
		send_item(OP_TICK);
		send_item(OP_LINK_DROP, RSN_NOT_FOUND);          // doubled value above the cap
	endtask

	// No credentials: no attempts, attempts untimed, scans still time out
	task automatic test_unconfigured();
		load_settings(16'd0, 16'd0, 16'd3, 16'd8, 16'd2);
		send_item(OP_RECONNECT);
		send_item(OP_TICK);
		send_item(OP_SCAN_REQ, 8'd0, 1'b1);
		repeat (3) send_item(OP_TICK);
		wait_all_results();
		write_reg(REG_NET_CONFIGURED, 16'd1);
		send_item(OP_RECONNECT);
		wait_all_results();
		write_reg(REG_NET_CONFIGURED, 16'hFFFE);         // only bit zero counts
		repeat (3) send_item(OP_TICK);
		send_item(OP_SCAN_REQ, 8'd0, 1'b1);
		send_item(OP_LINK_DROP, RSN_HANDSHAKE_FAIL);
	endtask

	// Stall the result side long enough to back up the request side
	task automatic test_backpressure();
		load_settings(16'd1, 16'd4, 16'd2, 16'd9, 16'd6);
		steady   = 1'b1;
		hold_ask = 80;
		repeat (40) send_random_item();
		steady = 1'b0;
		wait_all_results();
		repeat (20) send_random_item();
	endtask

	// Random traffic under several random settings
	task automatic test_random_traffic();
		logic [15:0] net;
		for (int p = 0; p < 5; p++) begin
			net    = 16'($urandom);
			net[0] = $urandom_range(0, 5) != 0;
			if (p == 3)
				load_settings(net, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom_range(0, 12)));
			else
				load_settings(net, 16'($urandom_range(0, 12)), 16'($urandom_range(0, 6)),
					16'($urandom_range(0, 30)), 16'($urandom_range(0, 10)));
			steady = (p == 2);
			repeat (75) send_random_item();
		end
		steady = 1'b0;
	endtask

	// Fail and retry back to back with no wait between attempts
	task automatic test_failure_streak();
		load_settings(16'd1, 16'd0, 16'd0, 16'd0, 16'd1);
		steady = 1'b1;
		send_item(OP_RECONNECT);
		repeat (24) send_item(OP_TICK);
		steady = 1'b0;
	endtask

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		s_tvalid    = 1'b0;
		s_tuser     = '0;
		s_tdata     = '0;
		m_tready    = 1'b0;
		fail_count  = 0;
		cycle_count = 0;
		steady      = 1'b0;
		hold_ask    = 0;
		hold_left   = 0;
		cfg_net_on  = 1'b0;
		cfg_conn_to = CONNECT_TIMEOUT_RST;
		cfg_bo_min  = BACKOFF_MIN_RST;
		cfg_bo_max  = BACKOFF_MAX_RST;
		cfg_scan_to = SCAN_TIMEOUT_RST;
		sv_phase    = PN_IDLE;
		sv_elapsed  = '0;
		sv_wait     = '0;
		sv_backoff  = '0;
		sv_fails    = '0;
		sv_last_err = CL_NONE;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: no credentials yet
		send_item(OP_TICK);
		send_item(OP_RECONNECT);
		test_phase_walk();
		test_drop_classes();
		test_timer_extremes();
		test_unconfigured();
		test_backpressure();
		test_random_traffic();
		test_failure_streak();
		wait_all_results();

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
